@@ sv/crc16fa_pkg.sv @@
// crc16fa_pkg: shared types, constants and the CRC-16 byte update for the frame appender.
// No dependencies; compile first.
package crc16fa_pkg;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // register map (byte address 4*index)
  localparam int unsigned CFG_AW         = 3;
  localparam logic        CFG_IDX_APPEND = 1'b0;

  // how the back end plays out one queued request
  typedef enum logic [1:0] {
    KIND_DATA,    // plain byte, no end mark
    KIND_LAST,    // final byte, carries end mark, no CRC
    KIND_APPEND   // final byte, followed by CRC low and high
  } kind_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] crc;
    kind_t       kind;
  } entry_t;

  // reflected CRC-16, LSB first, one bit per step
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  byte_in);
    logic [15:0] c;
    logic [7:0]  b;
    logic        fb;
    c = crc_in;
    b = byte_in;
    for (int k = 0; k < 8; k++) begin
      fb = b[0] ^ c[0];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      b = b >> 1;
    end
    return c;
  endfunction

endpackage

@@ sv/crc16fa_in_if.sv @@
// crc16fa_in_if: valid/ready channel carrying one frame byte and its last flag.
// No dependencies.
interface crc16fa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ sv/crc16fa_out_if.sv @@
// crc16fa_out_if: valid/ready channel carrying one line byte and its end-of-frame mark.
// No dependencies.
interface crc16fa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_frame;

  modport source (output valid, output out_byte, output end_of_frame, input ready);
  modport sink   (input valid, input out_byte, input end_of_frame, output ready);
endinterface

@@ sv/crc16fa_front.sv @@
// crc16fa_front: running CRC and classification of each accepted byte.
// Depends on crc16fa_pkg.
module crc16fa_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic                  append_crc,
  output crc16fa_pkg::entry_t   entry
);
  import crc16fa_pkg::*;

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [15:0] crc_upd;

  assign crc_upd = crc16_update(crc_r, data_byte);

  always_comb begin
    entry.data = data_byte;
    entry.crc  = crc_upd;
    priority if (!last_byte) begin
      entry.kind = KIND_DATA;
    end else if (append_crc) begin
      entry.kind = KIND_APPEND;
    end else begin
      entry.kind = KIND_LAST;
    end
  end

  // clear at frame end
  always_comb begin
    crc_nxt = crc_r;
    if (accept) begin
      crc_nxt = last_byte ? CRC_INIT : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule

@@ sv/crc16fa_queue.sv @@
// crc16fa_queue: small FIFO of classified requests between front and back end.
// Depends on crc16fa_pkg.
module crc16fa_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  crc16fa_pkg::entry_t   push_entry,
  input  logic                  pop,
  output logic                  full,
  output logic                  head_valid,
  output crc16fa_pkg::entry_t   head
);
  import crc16fa_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ sv/crc16fa_back.sv @@
// crc16fa_back: plays each queued request out as one or three line bytes.
// Depends on crc16fa_pkg.
module crc16fa_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  crc16fa_pkg::entry_t   head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_eof
);
  import crc16fa_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_eof_r;

  logic       load;
  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_eof;

  // output register free or draining this cycle
  assign load = !out_valid_r || out_ready;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_DATA: begin
        if (load && head_valid && head.kind == KIND_APPEND) begin
          phase_nxt = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        if (load) begin
          phase_nxt = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        if (load) begin
          phase_nxt = PH_DATA;
        end
      end
      default: phase_nxt = PH_DATA;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    pop       = 1'b0;
    emit_byte = head.data;
    emit_eof  = 1'b0;
    unique case (phase_r)
      PH_DATA: begin
        emit      = load && head_valid;
        emit_byte = head.data;
        emit_eof  = (head.kind == KIND_LAST);
        pop       = emit && (head.kind != KIND_APPEND);
      end
      PH_CRC_LO: begin
        emit      = load;
        emit_byte = head.crc[7:0];
      end
      PH_CRC_HI: begin
        emit      = load;
        emit_byte = head.crc[15:8];
        emit_eof  = 1'b1;
        pop       = load;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DATA;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_eof_r  <= emit_eof;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_eof   = out_eof_r;

endmodule

@@ sv/crc16_frame_appender.sv @@
// crc16_frame_appender: top level, byte stream with CRC-16/ARC appended at frame end.
// Depends on crc16fa_pkg, crc16fa_in_if, crc16fa_out_if, crc16fa_front, crc16fa_queue,
// crc16fa_back.
//
//   channel   dir  handshake           payload
//   in_ch     in   valid/ready         data_byte[7:0], last_byte
//   out_ch    out  valid/ready         out_byte[7:0], end_of_frame
//   cfg_*     in   APB write/read      append_crc at byte address 0
//
// Flow: one request per clock for ordinary bytes while out_ch.ready is high;
// a last byte with CRC append enabled yields three bytes (data, CRC low, CRC high).
// An input byte is registered into the queue, then into the output register.
// Reset (rst_n low, synchronous) clears the running CRC, queue and output valid,
// and sets append_crc to 1. No clearing pass is needed.
// Stalls: out_ch.ready low holds the output register; the queue keeps accepting
// until QUEUE_DEPTH requests are waiting, then in_ch.ready drops.
module crc16_frame_appender #(
  parameter int unsigned QUEUE_DEPTH = 2   // queued requests, 2 or more
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  crc16fa_in_if.sink                             in_ch,
  crc16fa_out_if.source                          out_ch,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [crc16fa_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [31:0]                            cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);
  import crc16fa_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration: single register, word index is paddr[2]
  // ---------------------------------------------------------------------------
  logic append_r, append_nxt;
  logic cfg_wr;
  logic cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == CFG_IDX_APPEND);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    append_nxt = append_r;
    if (cfg_wr && cfg_hit) begin
      append_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      append_r <= 1'b1;
    end else begin
      append_r <= append_nxt;
    end
  end

  assign cfg_prdata = cfg_hit ? {31'b0, append_r} : 32'b0;

  // ---------------------------------------------------------------------------
  // Front end: accept, update CRC, classify
  // ---------------------------------------------------------------------------
  entry_t in_entry;
  entry_t head;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  logic   in_accept;

  assign in_ch.ready = !q_full;
  assign in_accept   = in_ch.valid && !q_full;

  crc16fa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .data_byte  (in_ch.data_byte),
    .last_byte  (in_ch.last_byte),
    .append_crc (append_r),
    .entry      (in_entry)
  );

  // ---------------------------------------------------------------------------
  // Request queue between front and back end
  // ---------------------------------------------------------------------------
  crc16fa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_entry (in_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (head)
  );

  // ---------------------------------------------------------------------------
  // Back end: data byte, then optional CRC low/high, into the output register
  // ---------------------------------------------------------------------------
  crc16fa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (head),
    .pop        (q_pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .out_eof    (out_ch.end_of_frame)
  );

endmodule
